FILE: sv/i2a_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
`timescale 1ns / 1ps
package i2a_pkg;
  localparam int TextMax  = 18;
  localparam int DecDigits = 10;
  localparam int HexDigits = 16;

  typedef enum logic [2:0] {
    FMT_SDEC = 3'd0,
    FMT_UDEC = 3'd1,
    FMT_HEXL = 3'd2,
    FMT_HEXU = 3'd3,
    FMT_PTR  = 3'd4
  } fmt_t;

  // Digit/format item passed between stages.
  typedef struct packed {
    logic [2:0]  fmt;
    logic        neg;
    logic [63:0] mag;
  } req_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic        neg;
    logic [63:0] hex_mag;
    logic [39:0] bcd;      // ten BCD digits
  } dig_t;

  typedef logic [TextMax-1:0][7:0] text_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) r = 8'h30 + {4'd0, d};
    else if (upper) r = 8'h37 + {4'd0, d};
    else r = 8'h57 + {4'd0, d};
    return r;
  endfunction
endpackage

FILE: sv/i2a_bcd.sv
// Pipelined double-dabble: 32-bit binary to ten BCD digits, four bits per stage.
`timescale 1ns / 1ps
module i2a_bcd
  import i2a_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  req_t in_req,
  output logic out_valid,
  output dig_t out_dig
);
  localparam int Stages = 8;

  logic [Stages:0]        vld;
  req_t                   req [Stages+1];
  logic [39:0]            bcd [Stages+1];
  logic [31:0]            bin [Stages+1];

  assign vld[0] = in_valid;
  assign req[0] = in_req;
  assign bcd[0] = '0;
  assign bin[0] = in_req.mag[31:0];

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [39:0] b;
    logic [31:0] x;
    always_comb begin
      b = bcd[s];
      x = bin[s];
      for (int k = 0; k < 4; k++) begin
        for (int d = 0; d < 10; d++) begin
          if (b[d*4 +: 4] > 4'd4) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
        b = {b[38:0], x[31]};
        x = {x[30:0], 1'b0};
      end
    end
    logic        v_r;
    req_t        q_r;
    logic [39:0] b_r;
    logic [31:0] x_r;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vld[s];
      end
      if (en) begin
        q_r <= req[s];
        b_r <= b;
        x_r <= x;
      end
    end
    assign vld[s+1] = v_r;
    assign req[s+1] = q_r;
    assign bcd[s+1] = b_r;
    assign bin[s+1] = x_r;
  end

  assign out_valid       = vld[Stages];
  assign out_dig.fmt     = req[Stages].fmt;
  assign out_dig.neg     = req[Stages].neg;
  assign out_dig.hex_mag = req[Stages].mag;
  assign out_dig.bcd     = bcd[Stages];
endmodule

FILE: sv/i2a_emit.sv
// Text builder and character serializer.
`timescale 1ns / 1ps
module i2a_emit
  import i2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dig_t       in_dig,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic [4:0] out_count
);
  // Stage A: leading-digit count.
  logic        a_valid;
  dig_t        a_dig;
  logic [4:0]  a_nd;
  logic [4:0]  nd_next;

  always_comb begin
    nd_next = 5'd1;
    if (in_dig.fmt == FMT_SDEC || in_dig.fmt == FMT_UDEC) begin
      for (int d = 0; d < 10; d++)
        if (in_dig.bcd[d*4 +: 4] != 4'd0) nd_next = 5'(d + 1);
    end else if (in_dig.fmt == FMT_PTR) begin
      for (int d = 0; d < 16; d++)
        if (in_dig.hex_mag[d*4 +: 4] != 4'd0) nd_next = 5'(d + 1);
    end else begin
      for (int d = 0; d < 8; d++)
        if (in_dig.hex_mag[d*4 +: 4] != 4'd0) nd_next = 5'(d + 1);
    end
  end

  // Serializer state.
  logic        busy;
  text_t       text;
  logic [4:0]  len;
  logic [4:0]  pos;
  logic        a_ready;
  logic        take;

  assign take     = a_valid && (!busy || (out_ready && pos + 5'd1 == len));
  assign a_ready  = !a_valid || take;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready) begin
      a_dig <= in_dig;
      a_nd  <= nd_next;
    end
  end

  // Build the text from stage A.
  text_t       text_next;
  logic [4:0]  len_next;
  always_comb begin
    logic [4:0] pre;
    logic [3:0] dg;
    text_next = '0;
    pre = 5'd0;
    dg = 4'd0;
    if (a_dig.fmt == FMT_PTR && a_dig.hex_mag == 64'd0) begin
      text_next[0] = "(";
      text_next[1] = "n";
      text_next[2] = "i";
      text_next[3] = "l";
      text_next[4] = ")";
      len_next = 5'd5;
    end else begin
      if (a_dig.fmt == FMT_PTR) begin
        text_next[0] = "0";
        text_next[1] = "x";
        pre = 5'd2;
      end else if (a_dig.fmt == FMT_SDEC && a_dig.neg) begin
        text_next[0] = "-";
        pre = 5'd1;
      end
      for (int i = 0; i < 16; i++) begin
        if (5'(i) < a_nd) begin
          if (a_dig.fmt == FMT_SDEC || a_dig.fmt == FMT_UDEC)
            dg = a_dig.bcd[(a_nd - 5'(i) - 5'd1)*4 +: 4];
          else
            dg = a_dig.hex_mag[(a_nd - 5'(i) - 5'd1)*4 +: 4];
          text_next[pre + 5'(i)] = hex_char(dg, a_dig.fmt == FMT_HEXU);
        end
      end
      len_next = pre + a_nd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (busy && out_ready && pos + 5'd1 == len) begin
      busy <= 1'b0;
    end
    if (take) begin
      text <= text_next;
      len  <= len_next;
      pos  <= 5'd0;
    end else if (busy && out_ready) begin
      pos <= pos + 5'd1;
    end
  end

  assign out_valid = busy;
  assign out_char  = text[pos];
  assign out_last  = (pos + 5'd1 == len);
  assign out_count = out_last ? len : 5'd0;
endmodule

FILE: sv/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter.
`timescale 1ns / 1ps
// Formats one number per request as ASCII text, one character per output
// cycle while m_tready is high, most significant first; tlast marks the
// final character and tuser carries the character count (1 to 18) there.
// The serializer loads the next text as the last character leaves, while
// a ten-stage front end (sign fix, eight binary-to-BCD stages, digit count)
// overlaps the next requests. Unused format codes produce no output.
module integer_to_ascii_formatter_top
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [2:0] req_type, [66:3] value, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] character
  output logic        m_tlast,   // last
  output logic [4:0]  m_tuser    // [4:0] char_count
);
  logic [2:0]  req_type;
  logic [63:0] value;
  assign req_type = s_tdata[2:0];
  assign value    = s_tdata[66:3];

  // Pipeline advances when the output stage can absorb.
  logic en, p_valid, e_ready, b_valid;
  req_t p_req, p_req_next;
  dig_t b_dig;
  assign en       = e_ready || !b_valid;
  assign s_tready = en;

  always_comb begin
    p_req_next.fmt = req_type;
    p_req_next.neg = value[31] && req_type == FMT_SDEC;
    p_req_next.mag = (req_type == FMT_PTR) ? value :
                     {32'd0, p_req_next.neg ? (~value[31:0] + 32'd1) : value[31:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_tvalid && req_type <= FMT_PTR;
    end
    if (en) p_req <= p_req_next;
  end

  i2a_bcd u_bcd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p_valid), .in_req(p_req),
    .out_valid(b_valid), .out_dig(b_dig)
  );

  i2a_emit u_emit (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(e_ready), .in_dig(b_dig),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_char(m_tdata), .out_last(m_tlast), .out_count(m_tuser)
  );
endmodule

FILE: sv/i2a_checker.sv
// Port-level checker for the formatter, bound to the top level.
`timescale 1ns / 1ps
module i2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [4:0] m_tuser
);
  a_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == 5'd0) else $error("count off last");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser != 5'd0 && m_tuser <= 5'd18)
    else $error("count range");
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7]) else $error("non-ascii");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stall changed");
endmodule

bind integer_to_ascii_formatter_top i2a_checker u_chk (.*);
